/* hw/rtl/rpcc_pkg.sv */
`default_nettype none

package rpcc_pkg;

  localparam int NUM_LAYERS  = 6;
  localparam int COORD_WIDTH = 32;

  // fixed field widths
  localparam int IN_COORD_W = 32;
  localparam int LAYER_W    = 3;
  localparam int NET_W      = 16;
  localparam int COEF_W     = 24;
  localparam int GAP_W      = 20;
  localparam int CAP_W      = 48;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  // derived widths
  localparam int LIDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int CMP_W  = (COORD_WIDTH > GAP_W) ? COORD_WIDTH : GAP_W;
  localparam int NUM_W  = COEF_W + COORD_WIDTH;
  localparam int DIVD_W = (NUM_W > CAP_W) ? NUM_W : CAP_W + 1;

  localparam logic [CFG_IDX_W-1:0] MAX_GAP_IDX   = CFG_IDX_W'(6);
  localparam logic [GAP_W-1:0]     MAX_GAP_RESET = GAP_W'(2000);
  localparam logic [LAYER_W-1:0]   VIA_CODE      = LAYER_W'(7);

  typedef logic [NUM_LAYERS-1:0][COEF_W-1:0] coef_array_t;

  typedef struct packed {
    logic signed [IN_COORD_W-1:0] a_left;
    logic signed [IN_COORD_W-1:0] a_bottom;
    logic signed [IN_COORD_W-1:0] a_right;
    logic signed [IN_COORD_W-1:0] a_top;
    logic signed [IN_COORD_W-1:0] b_left;
    logic signed [IN_COORD_W-1:0] b_bottom;
    logic signed [IN_COORD_W-1:0] b_right;
    logic signed [IN_COORD_W-1:0] b_top;
    logic [LAYER_W-1:0]           a_layer;
    logic [LAYER_W-1:0]           b_layer;
    logic [NET_W-1:0]             a_net_id;
    logic [NET_W-1:0]             b_net_id;
  } pair_word_t;

  typedef struct packed {
    logic             coupled;
    logic [CAP_W-1:0] coupling_cap;
    logic [OUT_W-1:0] gap_out;
    logic [OUT_W-1:0] overlap_out;
  } cap_word_t;

  // word handed from cell to cell along the divider chain
  typedef struct packed {
    logic                   valid;
    logic                   coupled;
    logic                   sat;
    logic [GAP_W-1:0]       gap;
    logic [COORD_WIDTH-1:0] overlap;
    logic [GAP_W-1:0]       rem;
    logic [CAP_W-1:0]       shift;
  } cell_word_t;

endpackage

`default_nettype wire

/* hw/rtl/rpcc_if.sv */
`default_nettype none

interface rpcc_in_if import rpcc_pkg::*; ();
  logic       valid;
  logic       ready;
  pair_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpcc_out_if import rpcc_pkg::*; ();
  logic      valid;
  logic      ready;
  cap_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rpcc_front.sv */
`default_nettype none

module rpcc_front import rpcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire pair_word_t  in_data,
  input  wire coef_array_t layer_coef,
  input  wire logic [GAP_W-1:0] max_gap,
  output cell_word_t       head
);

  typedef struct packed {
    logic                   has;
    logic [COORD_WIDTH-1:0] gap;
    logic [COORD_WIDTH-1:0] ov;
  } axis_t;

  typedef struct packed {
    logic              valid;
    logic              pair_ok;
    logic [LIDX_W-1:0] layer;
    axis_t             x;
    axis_t             y;
  } s1_t;

  typedef struct packed {
    logic                   valid;
    logic                   coupled;
    logic [GAP_W-1:0]       gap;
    logic [COORD_WIDTH-1:0] overlap;
    logic [COEF_W-1:0]      coef;
  } s2_t;

  typedef struct packed {
    logic                   valid;
    logic                   coupled;
    logic [GAP_W-1:0]       gap;
    logic [COORD_WIDTH-1:0] overlap;
    logic [NUM_W-1:0]       num;
  } s3_t;

  function automatic logic signed [DIFF_W-1:0] coord(input logic [IN_COORD_W-1:0] v);
    return $signed({v[COORD_WIDTH-1], v[COORD_WIDTH-1:0]});
  endfunction

  // separation along one axis, overlap along the other
  function automatic axis_t axis_cand(
    input logic signed [DIFF_W-1:0] a0, input logic signed [DIFF_W-1:0] a1,
    input logic signed [DIFF_W-1:0] b0, input logic signed [DIFF_W-1:0] b1,
    input logic signed [DIFF_W-1:0] c0a, input logic signed [DIFF_W-1:0] c1a,
    input logic signed [DIFF_W-1:0] c0b, input logic signed [DIFF_W-1:0] c1b);
    logic                     le_ab;
    logic                     le_ba;
    logic signed [DIFF_W-1:0] g;
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    logic signed [DIFF_W-1:0] o;
    axis_t                    r;
    le_ab = a1 <= b0;
    le_ba = b1 <= a0;
    g     = le_ab ? b0 - a1 : a0 - b1;
    hi    = (c1a < c1b) ? c1a : c1b;
    lo    = (c0a > c0b) ? c0a : c0b;
    o     = hi - lo;
    r.has = (le_ab || le_ba) && (g != '0) && !o[DIFF_W-1] && (o != '0);
    r.gap = g[COORD_WIDTH-1:0];
    r.ov  = o[COORD_WIDTH-1:0];
    return r;
  endfunction

  logic signed [DIFF_W-1:0] al, ab, ar, at, bl, bb, br, bt;
  logic                     layer_ok;
  logic                     net_ok;

  s1_t s1;
  s2_t s2;
  s3_t s3;

  assign al = coord(in_data.a_left);
  assign ab = coord(in_data.a_bottom);
  assign ar = coord(in_data.a_right);
  assign at = coord(in_data.a_top);
  assign bl = coord(in_data.b_left);
  assign bb = coord(in_data.b_bottom);
  assign br = coord(in_data.b_right);
  assign bt = coord(in_data.b_top);

  assign layer_ok = (in_data.a_layer == in_data.b_layer) && (in_data.a_layer != VIA_CODE)
                    && (in_data.a_layer < LAYER_W'(NUM_LAYERS));
  assign net_ok   = !((in_data.a_net_id != '0) && (in_data.a_net_id == in_data.b_net_id));

  // stage 2 selection
  logic [CMP_W-1:0] gx_w;
  logic [CMP_W-1:0] gy_w;
  logic [CMP_W-1:0] radius_w;
  logic             pick_x;
  logic             gx_in;
  logic             gy_in;
  logic [CMP_W-1:0] g_sel;

  assign gx_w     = CMP_W'(s1.x.gap);
  assign gy_w     = CMP_W'(s1.y.gap);
  assign radius_w = CMP_W'(max_gap);
  assign pick_x   = s1.x.has && (!s1.y.has || (gx_w <= gy_w));
  assign gx_in    = gx_w <= radius_w;
  assign gy_in    = gy_w <= radius_w;
  assign g_sel    = pick_x ? gx_w : gy_w;

  // stage 3 multiply and stage 4 preparation of the divider
  logic [NUM_W-1:0]        prod;
  logic [DIVD_W-1:0]       dividend;
  logic [GAP_W-1:0]        pre_rem;

  assign prod     = s2.coef * s2.overlap;
  assign dividend = DIVD_W'(s3.num);
  assign pre_rem  = GAP_W'(dividend[DIVD_W-1:CAP_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      s2.valid   <= 1'b0;
      s3.valid   <= 1'b0;
      head.valid <= 1'b0;
    end else if (en) begin
      s1.valid   <= in_valid;
      s1.pair_ok <= layer_ok && net_ok;
      s1.layer   <= in_data.a_layer[LIDX_W-1:0];
      s1.x       <= axis_cand(al, ar, bl, br, ab, at, bb, bt);
      s1.y       <= axis_cand(ab, at, bb, bt, al, ar, bl, br);

      s2.valid   <= s1.valid;
      s2.coupled <= s1.pair_ok && (s1.x.has || s1.y.has) && (pick_x ? gx_in : gy_in);
      s2.gap     <= g_sel[GAP_W-1:0];
      s2.overlap <= pick_x ? s1.x.ov : s1.y.ov;
      s2.coef    <= layer_coef[s1.layer];

      s3.valid   <= s2.valid;
      s3.coupled <= s2.coupled;
      s3.gap     <= s2.gap;
      s3.overlap <= s2.overlap;
      s3.num     <= prod;

      // quotient bits above the cap width are nonzero exactly when the top part reaches the gap
      head.valid   <= s3.valid;
      head.coupled <= s3.coupled;
      head.sat     <= pre_rem >= s3.gap;
      head.gap     <= s3.gap;
      head.overlap <= s3.overlap;
      head.rem     <= pre_rem;
      head.shift   <= dividend[CAP_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rpcc_div_cell.sv */
`default_nettype none

module rpcc_div_cell import rpcc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire cell_word_t d,
  output cell_word_t      q
);

  logic [GAP_W:0] trial;
  logic [GAP_W:0] diff;
  logic           ge;
  cell_word_t     q_next;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {d.rem, d.shift[CAP_W-1]};
  assign diff  = trial - {1'b0, d.gap};
  assign ge    = trial >= {1'b0, d.gap};

  always_comb begin
    q_next       = d;
    q_next.rem   = ge ? diff[GAP_W-1:0] : trial[GAP_W-1:0];
    q_next.shift = {d.shift[CAP_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rect_pair_coupling_cap_core.sv */
`default_nettype none

// Lateral coupling capacitance between two rectangles on one metal layer. Each accepted
// pair gives exactly one result word, in order: coupled, floor(coef*overlap/gap)
// saturated to 48 bits in Q.16, the chosen gap and the overlap (all zero when not
// coupled). The block takes one pair per cycle while the skid stage is free; a pair
// passes through registers for geometry, selection, multiply and divider setup, then
// 48 divider cells of one quotient bit each, then the output register. An output
// register with a one-word skid stage keeps the input open while one result waits.
// Registers 0 to 5 hold the Q8.16 layer coefficients, register 6 the search radius in
// nm (reset 2000); write them only while no pair is in flight.
module rect_pair_coupling_cap_core import rpcc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rpcc_in_if.sink                    pairs,
  rpcc_out_if.source                 results
);

  coef_array_t      layer_coef;
  logic [GAP_W-1:0] max_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_coef <= '0;
      max_gap    <= MAX_GAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(NUM_LAYERS)) begin
        layer_coef[cfg_index[LIDX_W-1:0]] <= cfg_data[COEF_W-1:0];
      end else if (cfg_index == MAX_GAP_IDX) begin
        max_gap <= cfg_data[GAP_W-1:0];
      end
    end
  end

  logic       en;
  logic       out_valid;
  logic       skid_valid;
  cap_word_t  out_word;
  cap_word_t  skid_word;
  cap_word_t  res;
  cell_word_t chain [CAP_W+1];

  // the whole chain moves while the skid stage is free
  assign en           = !skid_valid;
  assign pairs.ready  = en;

  rpcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (pairs.valid),
    .in_data    (pairs.data),
    .layer_coef (layer_coef),
    .max_gap    (max_gap),
    .head       (chain[0])
  );

  for (genvar k = 0; k < CAP_W; k++) begin : g_cell
    rpcc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[k]),
      .q   (chain[k+1])
    );
  end

  always_comb begin
    res.coupled      = chain[CAP_W].coupled;
    res.coupling_cap = '0;
    res.gap_out      = '0;
    res.overlap_out  = '0;
    if (chain[CAP_W].coupled) begin
      res.coupling_cap = chain[CAP_W].sat ? '1 : chain[CAP_W].shift;
      res.gap_out      = OUT_W'(chain[CAP_W].gap);
      res.overlap_out  = OUT_W'(chain[CAP_W].overlap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (out_valid && !results.ready) begin
        if (chain[CAP_W].valid) begin
          skid_valid <= 1'b1;
          skid_word  <= res;
        end
      end else begin
        out_valid <= chain[CAP_W].valid;
        out_word  <= res;
      end
    end else if (results.ready) begin
      out_word   <= skid_word;
      skid_valid <= 1'b0;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_word;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && results.ready |=> !skid_valid)
    else $error("skid word not moved after output was taken");

  a_uncoupled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.coupled |->
      out_word.coupling_cap == '0 && out_word.gap_out == '0 && out_word.overlap_out == '0)
    else $error("uncoupled word carries nonzero fields");

  a_coupled_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.coupled |->
      out_word.gap_out != '0 && out_word.gap_out[OUT_W-1:GAP_W] == '0)
    else $error("coupled word with gap out of range");

endmodule

`default_nettype wire

/* tb/sv/rect_pair_coupling_cap_core_tb.sv */
`timescale 1ns / 100ps

module rect_pair_coupling_cap_core_tb;
  import rpcc_pkg::*;

  localparam int PIPE_LAT    = 53;
  localparam int HOLD_CYCLES = 400;
  localparam int C_MIN       = 32'sh8000_0000;
  localparam int C_MAX       = 32'sh7fff_ffff;
  localparam logic [63:0] CAP_MAX = (64'd1 << CAP_W) - 64'd1;
  localparam logic [COEF_W-1:0] COEF_FULL = '1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rpcc_in_if  pairs_if ();
  rpcc_out_if results_if ();

  rect_pair_coupling_cap_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pairs     (pairs_if),
    .results   (results_if)
  );

  // local copy of the register file
  logic [COEF_W-1:0] coef_model [NUM_LAYERS];
  logic [GAP_W-1:0]  gap_limit;
  logic [COEF_W-1:0] coef_plan [NUM_LAYERS];

  pair_word_t pair_q[$];
  cap_word_t  cap_due_q[$];
  cap_word_t  cap_seen;
  cap_word_t  cap_want;

  int fails = 0;
  int src_idle = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one separation axis: gap along a, overlap along c
  function automatic bit axis_hit(input longint a0, input longint a1, input longint b0,
                                  input longint b1, input longint c0a, input longint c1a,
                                  input longint c0b, input longint c1b,
                                  output longint g, output longint o);
    longint gg;
    longint oo;
    g = 0;
    o = 0;
    if (a1 <= b0) gg = b0 - a1;
    else if (b1 <= a0) gg = a0 - b1;
    else return 1'b0;
    oo = ((c1a < c1b) ? c1a : c1b) - ((c0a > c0b) ? c0a : c0b);
    if (gg <= 0 || oo <= 0) return 1'b0;
    g = gg;
    o = oo;
    return 1'b1;
  endfunction

  function automatic cap_word_t predict_cap(input pair_word_t p);
    cap_word_t r;
    longint al, ab, ar, at, bl, bb, br, bt;
    longint gx, ox, gy, oy, g, o;
    bit hx, hy;
    logic [63:0] prod;
    logic [63:0] quo;
    r = '0;
    al = longint'($signed(p.a_left));
    ab = longint'($signed(p.a_bottom));
    ar = longint'($signed(p.a_right));
    at = longint'($signed(p.a_top));
    bl = longint'($signed(p.b_left));
    bb = longint'($signed(p.b_bottom));
    br = longint'($signed(p.b_right));
    bt = longint'($signed(p.b_top));
    if (p.a_layer != p.b_layer || p.a_layer == VIA_CODE || p.b_layer == VIA_CODE) return r;
    if (p.a_layer >= NUM_LAYERS) return r;
    if (p.a_net_id != '0 && p.a_net_id == p.b_net_id) return r;
    hx = axis_hit(al, ar, bl, br, ab, at, bb, bt, gx, ox);
    hy = axis_hit(ab, at, bb, bt, al, ar, bl, br, gy, oy);
    if (!hx && !hy) return r;
    // tie goes to the x-separated candidate
    if (hx && (!hy || gx <= gy)) begin
      g = gx;
      o = ox;
    end else begin
      g = gy;
      o = oy;
    end
    if (g > longint'(gap_limit)) return r;
    prod = 64'(coef_model[p.a_layer]) * 64'(o);
    quo = prod / 64'(g);
    if (quo > CAP_MAX) quo = CAP_MAX;
    r.coupled      = 1'b1;
    r.coupling_cap = quo[CAP_W-1:0];
    r.gap_out      = OUT_W'(g);
    r.overlap_out  = OUT_W'(o);
    return r;
  endfunction

  function automatic pair_word_t rect_pair(input int al, input int ab, input int ar,
                                           input int at, input int bl, input int bb,
                                           input int br, input int bt, input int la,
                                           input int lb, input int na, input int nb);
    pair_word_t p;
    p.a_left   = al;
    p.a_bottom = ab;
    p.a_right  = ar;
    p.a_top    = at;
    p.b_left   = bl;
    p.b_bottom = bb;
    p.b_right  = br;
    p.b_top    = bt;
    p.a_layer  = LAYER_W'(la);
    p.b_layer  = LAYER_W'(lb);
    p.a_net_id = NET_W'(na);
    p.b_net_id = NET_W'(nb);
    return p;
  endfunction

  // two nearby shapes on one layer, gap spread around the search radius
  function automatic pair_word_t near_pair(input int radius);
    int x0, y0, w, h, w2, h2, gap, slide, lay, na, nb;
    int bl, bb, br, bt;
    x0 = int'($urandom_range(0, 20_000_000)) - 10_000_000;
    y0 = int'($urandom_range(0, 20_000_000)) - 10_000_000;
    w  = $urandom_range(1, 4000);
    h  = $urandom_range(1, 4000);
    w2 = $urandom_range(1, 4000);
    h2 = $urandom_range(1, 4000);
    case ($urandom_range(0, 9))
      0: gap = (radius > 0) ? radius : 1;
      1: gap = radius + 1;
      2: gap = $urandom_range(1, 3);
      default: gap = $urandom_range(1, radius + radius / 4 + 1);
    endcase
    if ($urandom_range(0, 1)) begin
      slide = int'($urandom_range(0, h + h2)) - h2;
      bl = x0 + w + gap;
      br = bl + w2;
      bb = y0 + slide;
      bt = bb + h2;
    end else begin
      slide = int'($urandom_range(0, w + w2)) - w2;
      bb = y0 + h + gap;
      bt = bb + h2;
      bl = x0 + slide;
      br = bl + w2;
    end
    lay = $urandom_range(0, NUM_LAYERS - 1);
    case ($urandom_range(0, 3))
      0: begin
        na = 0;
        nb = 0;
      end
      1: begin
        na = $urandom_range(1, 65535);
        nb = 0;
      end
      default: begin
        na = $urandom_range(0, 65535);
        nb = $urandom_range(0, 65535);
      end
    endcase
    if ($urandom_range(0, 1))
      return rect_pair(bl, bb, br, bt, x0, y0, x0 + w, y0 + h, lay, lay, nb, na);
    return rect_pair(x0, y0, x0 + w, y0 + h, bl, bb, br, bt, lay, lay, na, nb);
  endfunction

  function automatic pair_word_t random_pair();
    pair_word_t p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      p.a_left   = $urandom;
      p.a_bottom = $urandom;
      p.a_right  = $urandom;
      p.a_top    = $urandom;
      p.b_left   = $urandom;
      p.b_bottom = $urandom;
      p.b_right  = $urandom;
      p.b_top    = $urandom;
      p.a_layer  = LAYER_W'($urandom_range(0, 7));
      p.b_layer  = $urandom_range(0, 1) ? p.a_layer : LAYER_W'($urandom_range(0, 7));
      p.a_net_id = NET_W'($urandom_range(0, 65535));
      p.b_net_id = NET_W'($urandom_range(0, 65535));
      return p;
    end
    p = near_pair(int'(gap_limit));
    if (pick < 28) begin
      case ($urandom_range(0, 4))
        0: p.b_layer = p.a_layer + LAYER_W'($urandom_range(1, 7));
        1: begin
          p.a_layer = VIA_CODE;
          if ($urandom_range(0, 1)) p.b_layer = VIA_CODE;
        end
        2: begin
          p.a_layer = LAYER_W'(NUM_LAYERS);
          p.b_layer = LAYER_W'(NUM_LAYERS);
        end
        3: begin
          p.a_net_id = NET_W'($urandom_range(1, 65535));
          p.b_net_id = p.a_net_id;
        end
        default: begin
          // flipped edges on one shape
          if ($urandom_range(0, 1)) {p.a_left, p.a_right} = {p.a_right, p.a_left};
          else {p.b_bottom, p.b_top} = {p.b_top, p.b_bottom};
        end
      endcase
    end
    return p;
  endfunction

  task automatic shuffle_coefs();
    foreach (coef_plan[i]) begin
      case ($urandom_range(0, 5))
        0: coef_plan[i] = '0;
        1: coef_plan[i] = COEF_FULL;
        default: coef_plan[i] = COEF_W'($urandom_range(0, 24'hff_ffff));
      endcase
    end
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] gap_word);
    for (int i = 0; i < NUM_LAYERS; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= coef_plan[i];
      coef_model[i] = coef_plan[i];
    end
    @(posedge clk);
    cfg_index <= MAX_GAP_IDX;
    cfg_data  <= gap_word;
    gap_limit = gap_word[GAP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every pair is sent and every result is back, then let the pipe settle
  task automatic drain();
    while (pair_q.size() != 0 || pairs_if.valid || cap_due_q.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic queue_pair(input pair_word_t p);
    pair_q.insert(pair_q.size(), p);
  endtask

  // pair driver
  always @(posedge clk) begin
    if (rst) begin
      pairs_if.valid <= 1'b0;
      src_idle = 0;
    end else begin
      if (pairs_if.valid && pairs_if.ready)
        cap_due_q.insert(cap_due_q.size(), predict_cap(pairs_if.data));
      if (!pairs_if.valid || pairs_if.ready) begin
        if (src_idle > 0) begin
          src_idle--;
          pairs_if.valid <= 1'b0;
        end else if (pair_q.size() == 0) begin
          pairs_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_idle = $urandom_range(0, 6);
          pairs_if.valid <= 1'b0;
        end else begin
          pairs_if.valid <= 1'b1;
          pairs_if.data  <= pair_q.pop_front();
        end
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        cap_seen = results_if.data;
        if (cap_due_q.size() == 0) begin
          $error("unexpected result word: coupled %0d cap %0h gap %0d overlap %0d",
                 cap_seen.coupled, cap_seen.coupling_cap, cap_seen.gap_out,
                 cap_seen.overlap_out);
          fails++;
        end else begin
          cap_want = cap_due_q.pop_front();
          if (cap_seen.coupled !== cap_want.coupled) begin
            $error("coupled: expected %0d, got %0d", cap_want.coupled, cap_seen.coupled);
            fails++;
          end
          if (cap_seen.coupling_cap !== cap_want.coupling_cap) begin
            $error("coupling_cap: expected %0h, got %0h", cap_want.coupling_cap,
                   cap_seen.coupling_cap);
            fails++;
          end
          if (cap_seen.gap_out !== cap_want.gap_out) begin
            $error("gap_out: expected %0d, got %0d", cap_want.gap_out, cap_seen.gap_out);
            fails++;
          end
          if (cap_seen.overlap_out !== cap_want.overlap_out) begin
            $error("overlap_out: expected %0d, got %0d", cap_want.overlap_out,
                   cap_seen.overlap_out);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else if (hold_req) begin
        // long hold so the pipe fills and back-pressures the input
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        results_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pairs_if.valid = 1'b0;
    pairs_if.data = '0;
    results_if.ready = 1'b0;
    foreach (coef_model[i]) coef_model[i] = '0;
    gap_limit = MAX_GAP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // values after reset
    repeat (6) queue_pair(near_pair(int'(gap_limit)));
    drain();

    // directed pairs
    coef_plan[0] = COEF_FULL;
    coef_plan[1] = '0;
    coef_plan[2] = 24'd1;
    coef_plan[3] = 24'h01_0000;
    coef_plan[4] = 24'h80_0000;
    coef_plan[5] = COEF_W'($urandom_range(0, 24'hff_ffff));
    load_regs(CFG_DATA_W'(2000));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 20, 300, 80, 0, 0, 1, 2));
    queue_pair(rect_pair(0, 0, 100, 100, 10, 300, 90, 400, 5, 5, 0, 0));
    queue_pair(rect_pair(1000, 0, 1100, 50, 0, -10, 900, 10, 2, 2, 3, 4));
    queue_pair(rect_pair(0, 500, 40, 600, -20, 0, 20, 300, 3, 3, 0, 9));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 20, 300, 80, 0, 1, 1, 2));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 20, 300, 80, VIA_CODE, VIA_CODE, 1, 2));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 20, 300, 80, NUM_LAYERS, NUM_LAYERS,
                         1, 2));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 20, 300, 80, 0, 0, 5, 5));
    queue_pair(rect_pair(0, 0, 10, 10, 11, 0, 20, 10, 4, 4, 65535, 65534));
    // gap at the radius, one past it, touching, corner only
    queue_pair(rect_pair(0, 0, 100, 100, 2100, 0, 2200, 100, 0, 0, 0, 0));
    queue_pair(rect_pair(0, 0, 100, 100, 2101, 0, 2200, 100, 0, 0, 0, 0));
    queue_pair(rect_pair(0, 0, 100, 100, 100, 0, 200, 100, 0, 0, 0, 0));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 100, 200, 200, 0, 0, 0, 0));
    queue_pair(rect_pair(100, 0, 0, 100, 150, 20, 300, 80, 2, 2, 0, 7));
    // full-range overlap with gap 1 saturates
    queue_pair(rect_pair(C_MIN, C_MIN, 0, C_MAX, 1, C_MIN, C_MAX, C_MAX, 0, 0, 0, 0));
    queue_pair(rect_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         0, 0, 0, 0));
    queue_pair(rect_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                         7, 7, 65535, 65535));
    queue_pair(rect_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX,
                         5, 5, 0, 0));
    queue_pair(rect_pair(0, 0, 100, 100, 150, 20, 300, 80, 1, 1, 1, 2));
    queue_pair(rect_pair(0, 0, 10, 10, 9, 11, 30, 20, 3, 3, 0, 0));
    repeat (3) queue_pair(random_pair());
    drain();

    // random coefficients, long receiver hold
    shuffle_coefs();
    load_regs(CFG_DATA_W'($urandom_range(1, 5000)));
    repeat (150) queue_pair(random_pair());
    hold_req = 1'b1;
    drain();

    // zero radius never couples
    foreach (coef_plan[i]) coef_plan[i] = COEF_FULL;
    load_regs('0);
    repeat (40) queue_pair(random_pair());
    drain();

    // widest radius, junk in the unused data bits
    shuffle_coefs();
    load_regs({CFG_DATA_W'($urandom_range(0, 15)) << GAP_W} | CFG_DATA_W'(20'hf_ffff));
    repeat (150) queue_pair(random_pair());
    drain();

    shuffle_coefs();
    load_regs(CFG_DATA_W'(64));
    repeat (100) queue_pair(random_pair());
    drain();

    // last stretch at full rate on both sides
    calm = 1'b1;
    shuffle_coefs();
    load_regs(CFG_DATA_W'($urandom_range(1, 3000)));
    repeat (150) queue_pair(random_pair());
    drain();

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rpcc_pkg.sv
hw/rtl/rpcc_if.sv
hw/rtl/rpcc_front.sv
hw/rtl/rpcc_div_cell.sv
hw/rtl/rect_pair_coupling_cap_core.sv
tb/sv/rect_pair_coupling_cap_core_tb.sv
